// ===== rtl/ofam_pkg.sv =====
package ofam_pkg;

    localparam logic [15:0] PAGE_HIGH = 16'hFF00;

    localparam logic [4:0] M_IMP    = 5'd0;
    localparam logic [4:0] M_R      = 5'd1;
    localparam logic [4:0] M_R_R    = 5'd2;
    localparam logic [4:0] M_R_D8   = 5'd3;
    localparam logic [4:0] M_R_D16  = 5'd4;
    localparam logic [4:0] M_D16    = 5'd5;
    localparam logic [4:0] M_MR_R   = 5'd6;
    localparam logic [4:0] M_R_MR   = 5'd7;
    localparam logic [4:0] M_R_HLI  = 5'd8;
    localparam logic [4:0] M_R_HLD  = 5'd9;
    localparam logic [4:0] M_HLI_R  = 5'd10;
    localparam logic [4:0] M_HLD_R  = 5'd11;
    localparam logic [4:0] M_R_A8   = 5'd12;
    localparam logic [4:0] M_A8_R   = 5'd13;
    localparam logic [4:0] M_HL_SPR = 5'd14;
    localparam logic [4:0] M_D8     = 5'd15;
    localparam logic [4:0] M_A16_R  = 5'd16;
    localparam logic [4:0] M_D16_R  = 5'd17;
    localparam logic [4:0] M_MR_D8  = 5'd18;
    localparam logic [4:0] M_MR     = 5'd19;
    localparam logic [4:0] M_R_A16  = 5'd20;
    localparam logic [4:0] MODE_LAST = M_R_A16;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_UNKNOWN = 2'd2,
        KIND_PROTO   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] read_address;
        logic [15:0] operand_value;
        logic [15:0] dest_address;
        logic        dest_is_memory;
        logic [15:0] new_pc;
        logic [15:0] new_hl;
        logic        hl_changed;
    } res_t;

    typedef struct packed {
        logic        busy;
        logic [4:0]  pending_mode;
        logic [1:0]  reads_done;
        logic [7:0]  low_byte;
        logic [15:0] saved_pc;
        logic [15:0] saved_first;
        logic [15:0] saved_second;
        logic [15:0] saved_hl;
    } fetch_state_t;

    function automatic logic [1:0] reads_needed(input logic [4:0] m);
        logic [1:0] n;
        unique case (m)
            M_R_D8, M_R_MR, M_R_HLI, M_R_HLD, M_R_A8, M_A8_R,
            M_HL_SPR, M_D8, M_MR_D8, M_MR:
                n = 2'd1;
            M_R_D16, M_D16, M_A16_R, M_D16_R:
                n = 2'd2;
            M_R_A16:
                n = 2'd3;
            default:
                n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/ofam_step.sv =====
module ofam_step (
    input  logic                  action,
    input  logic [4:0]            mode,
    input  logic                  first_is_c,
    input  logic                  second_is_c,
    input  logic [15:0]           first_value,
    input  logic [15:0]           second_value,
    input  logic [15:0]           pc_value,
    input  logic [15:0]           hl_value,
    input  logic [7:0]            bus_byte,
    input  ofam_pkg::fetch_state_t st,
    output ofam_pkg::fetch_state_t st_next,
    output ofam_pkg::res_t        res
);
    import ofam_pkg::*;

    function automatic res_t finish(input fetch_state_t s, input logic [15:0] v,
                                    input logic c1);
        res_t r;
        r = '0;
        r.kind = KIND_DONE;
        r.new_pc = s.saved_pc;
        r.new_hl = s.saved_hl;
        unique case (s.pending_mode)
            M_R:
                r.operand_value = s.saved_first;
            M_R_R:
                r.operand_value = s.saved_second;
            M_R_D8, M_R_A8, M_HL_SPR, M_D8:
            begin
                r.operand_value = v;
                r.new_pc = s.saved_pc + 16'd1;
            end
            M_R_D16, M_D16, M_R_A16:
            begin
                r.operand_value = v;
                r.new_pc = s.saved_pc + 16'd2;
            end
            M_MR_R:
            begin
                r.operand_value = s.saved_second;
                r.dest_address = s.saved_first | (c1 ? PAGE_HIGH : 16'h0000);
                r.dest_is_memory = 1'b1;
            end
            M_R_MR:
                r.operand_value = v;
            M_R_HLI:
            begin
                r.operand_value = v;
                r.new_hl = s.saved_hl + 16'd1;
                r.hl_changed = 1'b1;
            end
            M_R_HLD:
            begin
                r.operand_value = v;
                r.new_hl = s.saved_hl - 16'd1;
                r.hl_changed = 1'b1;
            end
            M_HLI_R:
            begin
                r.operand_value = s.saved_second;
                r.dest_address = s.saved_first;
                r.dest_is_memory = 1'b1;
                r.new_hl = s.saved_hl + 16'd1;
                r.hl_changed = 1'b1;
            end
            M_HLD_R:
            begin
                r.operand_value = s.saved_second;
                r.dest_address = s.saved_first;
                r.dest_is_memory = 1'b1;
                r.new_hl = s.saved_hl - 16'd1;
                r.hl_changed = 1'b1;
            end
            M_A8_R:
            begin
                r.dest_address = PAGE_HIGH | {8'h00, v[7:0]};
                r.dest_is_memory = 1'b1;
                r.new_pc = s.saved_pc + 16'd1;
            end
            M_A16_R, M_D16_R:
            begin
                r.operand_value = s.saved_second;
                r.dest_address = v;
                r.dest_is_memory = 1'b1;
                r.new_pc = s.saved_pc + 16'd2;
            end
            M_MR_D8:
            begin
                r.operand_value = v;
                r.dest_address = s.saved_first;
                r.dest_is_memory = 1'b1;
                r.new_pc = s.saved_pc + 16'd1;
            end
            M_MR:
            begin
                r.operand_value = v;
                r.dest_address = s.saved_first;
                r.dest_is_memory = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    fetch_state_t start_st;
    logic [1:0]   need_start;
    logic [1:0]   need_pending;
    logic [15:0]  start_addr;
    logic [15:0]  word;

    always_comb
    begin
        start_st = '0;
        start_st.pending_mode = mode;
        start_st.saved_first = first_value;
        start_st.saved_second = second_value;
        start_st.saved_pc = pc_value;
        start_st.saved_hl = hl_value;
        need_start = reads_needed(mode);
        need_pending = reads_needed(st.pending_mode);
        word = {bus_byte, st.low_byte};

        priority if (mode == M_R_MR)
            start_addr = second_value | (second_is_c ? PAGE_HIGH : 16'h0000);
        else if (mode == M_R_HLI || mode == M_R_HLD)
            start_addr = second_value;
        else if (mode == M_MR)
            start_addr = first_value;
        else
            start_addr = pc_value;

        st_next = st;
        res = '0;

        if (action == ACT_START)
        begin
            st_next.busy = 1'b0;
            if (mode > MODE_LAST)
            begin
                res.kind = KIND_UNKNOWN;
            end
            else
            begin
                st_next = start_st;
                if (need_start == 2'd0)
                begin
                    res = finish(start_st, 16'h0000, first_is_c);
                end
                else
                begin
                    st_next.busy = 1'b1;
                    res.kind = KIND_READ;
                    res.read_address = start_addr;
                end
            end
        end
        else if (!st.busy)
        begin
            res.kind = KIND_PROTO;
        end
        else
        begin
            st_next.reads_done = st.reads_done + 2'd1;
            unique case (st.reads_done)
                2'd0:
                begin
                    st_next.low_byte = bus_byte;
                    if (need_pending == 2'd1)
                    begin
                        st_next.busy = 1'b0;
                        res = finish(st, {8'h00, bus_byte}, 1'b0);
                    end
                    else
                    begin
                        res.kind = KIND_READ;
                        res.read_address = st.saved_pc + 16'd1;
                    end
                end
                2'd1:
                begin
                    if (need_pending == 2'd2)
                    begin
                        st_next.busy = 1'b0;
                        res = finish(st, word, 1'b0);
                    end
                    else
                    begin
                        res.kind = KIND_READ;
                        res.read_address = word;
                    end
                end
                default:
                begin
                    st_next.busy = 1'b0;
                    res = finish(st, {8'h00, bus_byte}, 1'b0);
                end
            endcase
        end
    end

endmodule

// ===== rtl/ofam_outreg.sv =====
module ofam_outreg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            load,
    input  ofam_pkg::res_t  res,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      kind,
    output logic [15:0]     read_address,
    output logic [15:0]     operand_value,
    output logic [15:0]     dest_address,
    output logic            dest_is_memory,
    output logic [15:0]     new_pc,
    output logic [15:0]     new_hl,
    output logic            hl_changed
);
    import ofam_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign in_stall = valid_reg && out_stall;
    assign load = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign kind = res_reg.kind;
    assign read_address = res_reg.read_address;
    assign operand_value = res_reg.operand_value;
    assign dest_address = res_reg.dest_address;
    assign dest_is_memory = res_reg.dest_is_memory;
    assign new_pc = res_reg.new_pc;
    assign new_hl = res_reg.new_hl;
    assign hl_changed = res_reg.hl_changed;

    a_not_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.kind != KIND_DONE |->
            !res_reg.hl_changed && !res_reg.dest_is_memory && res_reg.new_pc == 16'h0000)
        else $error("Non-final result carries completion fields.");

    a_read_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.kind == KIND_DONE |-> res_reg.read_address == 16'h0000)
        else $error("Final result carries a read address.");

endmodule

// ===== rtl/operand_fetch_addressing_modes.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    action, mode, first_is_c, second_is_c,
//                                             first_value, second_value, pc_value,
//                                             hl_value, bus_byte
// output    out        out_valid / out_stall  kind, read_address, operand_value,
//                                             dest_address, dest_is_memory, new_pc,
//                                             new_hl, hl_changed
//
// One transaction is accepted per cycle unless the input is stalled, and each produces exactly one result transaction.
// The result appears in the output register on the cycle after acceptance.
// The fetch state is updated in the same single pass from the input and the saved state.
// The input stalls only when the output register is full and the output is stalled.
// Reset clears the fetch state and empties the output register.
module operand_fetch_addressing_modes (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [4:0]  mode,
    input  logic        first_is_c,
    input  logic        second_is_c,
    input  logic [15:0] first_value,
    input  logic [15:0] second_value,
    input  logic [15:0] pc_value,
    input  logic [15:0] hl_value,
    input  logic [7:0]  bus_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] read_address,
    output logic [15:0] operand_value,
    output logic [15:0] dest_address,
    output logic        dest_is_memory,
    output logic [15:0] new_pc,
    output logic [15:0] new_hl,
    output logic        hl_changed
);
    import ofam_pkg::*;

    fetch_state_t st_reg;
    fetch_state_t st_next;
    res_t         res;
    logic         load;

    ofam_step u_step (
        .action       (action),
        .mode         (mode),
        .first_is_c   (first_is_c),
        .second_is_c  (second_is_c),
        .first_value  (first_value),
        .second_value (second_value),
        .pc_value     (pc_value),
        .hl_value     (hl_value),
        .bus_byte     (bus_byte),
        .st           (st_reg),
        .st_next      (st_next),
        .res          (res)
    );

    ofam_outreg u_outreg (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .load           (load),
        .res            (res),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .read_address   (read_address),
        .operand_value  (operand_value),
        .dest_address   (dest_address),
        .dest_is_memory (dest_is_memory),
        .new_pc         (new_pc),
        .new_hl         (new_hl),
        .hl_changed     (hl_changed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (load)
        begin
            st_reg <= st_next;
        end
    end

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.busy |-> st_reg.reads_done != 2'd3)
        else $error("Fetch is busy after its last byte.");

    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        load && action == ACT_BYTE && !st_reg.busy |=>
            out_valid && kind == KIND_PROTO && $stable(st_reg))
        else $error("Byte without a pending fetch was not rejected.");

    a_unknown_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load && action == ACT_START && mode > MODE_LAST |=>
            !st_reg.busy && kind == KIND_UNKNOWN)
        else $error("Unknown mode left the fetch busy.");

endmodule
